@@ hw/rtl/positional_pair_list_assert.svh @@
// assertion macros for the positional pair list rtl
// no dependencies; included by the modules that carry checks
`ifndef POSITIONAL_PAIR_LIST_ASSERT_SVH
`define POSITIONAL_PAIR_LIST_ASSERT_SVH
`ifndef ASSERT_OFF
`define PPL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PPL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PPL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PPL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/ppl_pkg.sv @@
// types and constants shared by the positional pair list modules
// no dependencies
package ppl_pkg;

   typedef enum logic [3:0] {
      CMD_INS_HEAD = 4'd0,
      CMD_INS_TAIL = 4'd1,
      CMD_INS_POS  = 4'd2,
      CMD_RD_HEAD  = 4'd3,
      CMD_RD_TAIL  = 4'd4,
      CMD_RD_POS   = 4'd5,
      CMD_DEL_HEAD = 4'd6,
      CMD_DEL_TAIL = 4'd7,
      CMD_DEL_POS  = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]         command;
      logic [6:0]         position;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_first;
      logic signed [31:0] out_second;
      logic [6:0]         count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] first;
      logic signed [31:0] second;
   } pair_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_INS  = 2'd1,
      CELL_DEL  = 2'd2
   } cell_op_type;

   typedef struct packed {
      logic        load;
      cell_op_type op;
      logic        rd;
   } cell_ctrl_type;

   localparam logic signed [31:0] NONE_VALUE = -32'sd1;

endpackage

@@ hw/rtl/positional_pair_list.sv @@
// positional pair list: ordered list of up to DEPTH signed pairs, one cell per entry
// response path: cell read registers, then the registered or-tree, then rsp_word with rsp_valid
// one word at a time: req_stall holds new words until the response is loaded; the read or-tree moves one level a cycle
// reset synchronously clears length and handshake state; cell contents stay undefined until written
// depends on ppl_pkg, ppl_chain, ppl_cell and positional_pair_list_assert.svh
`include "positional_pair_list_assert.svh"
module positional_pair_list import ppl_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int IW   = $clog2(DEPTH);
   localparam int LENW = $clog2(DEPTH + 1);
   localparam int LW   = (LENW > 7) ? LENW : 7;
   localparam int CW   = $clog2(IW + 1);

   logic [LENW-1:0] len_ff, len_in;
   logic            busy_ff, busy_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_word_ff, rsp_word_in;
   status_type      pend_status_ff, pend_status_in;
   logic            pend_read_ff, pend_read_in;
   logic [6:0]      pend_count_ff, pend_count_in;

   logic [LW-1:0]   len_x, pos_x, at_x, len_next_x;
   logic            full, empty;
   status_type      st;
   cell_op_type     op;
   logic            rd;
   logic            accept, done, rsp_load;
   cell_ctrl_type   ctrl;
   pair_type        new_pair, root;

   assign len_x = LW'(len_ff);
   assign pos_x = LW'(req_word.position);
   assign full  = (len_ff == LENW'(DEPTH));
   assign empty = (len_ff == '0);

   always_comb begin
      st    = ST_OK;
      at_x  = '0;
      op    = CELL_HOLD;
      rd    = 1'b0;
      unique case (cmd_type'(req_word.command))
         CMD_INS_HEAD: begin
            if (full) st = ST_FULL;
            else op = CELL_INS;
         end
         CMD_INS_TAIL: begin
            if (full) st = ST_FULL;
            else begin
               op   = CELL_INS;
               at_x = len_x;
            end
         end
         CMD_INS_POS: begin
            priority if (full) st = ST_FULL;
            else if (pos_x > len_x) st = ST_BADPOS;
            else begin
               op   = CELL_INS;
               at_x = pos_x;
            end
         end
         CMD_RD_HEAD: begin
            if (empty) st = ST_EMPTY;
            else rd = 1'b1;
         end
         CMD_RD_TAIL: begin
            if (empty) st = ST_EMPTY;
            else begin
               rd   = 1'b1;
               at_x = len_x - LW'(1);
            end
         end
         CMD_RD_POS: begin
            priority if (empty) st = ST_EMPTY;
            else if (pos_x >= len_x) st = ST_BADPOS;
            else begin
               rd   = 1'b1;
               at_x = pos_x;
            end
         end
         CMD_DEL_HEAD: begin
            if (empty) st = ST_EMPTY;
            else begin
               rd = 1'b1;
               op = CELL_DEL;
            end
         end
         CMD_DEL_TAIL: begin
            if (empty) st = ST_EMPTY;
            else begin
               rd   = 1'b1;
               op   = CELL_DEL;
               at_x = len_x - LW'(1);
            end
         end
         CMD_DEL_POS: begin
            priority if (empty) st = ST_EMPTY;
            else if (pos_x >= len_x) st = ST_BADPOS;
            else begin
               rd   = 1'b1;
               op   = CELL_DEL;
               at_x = pos_x;
            end
         end
         default: st = ST_BADPOS;
      endcase
   end

   always_comb begin
      unique case (op)
         CELL_INS: len_next_x = len_x + LW'(1);
         CELL_DEL: len_next_x = len_x - LW'(1);
         default:  len_next_x = len_x;
      endcase
   end

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;

   assign ctrl.load = accept;
   assign ctrl.op   = op;
   assign ctrl.rd   = rd;
   assign new_pair.first  = req_word.first_value;
   assign new_pair.second = req_word.second_value;

   ppl_chain #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .at       (at_x[IW-1:0]),
      .new_pair (new_pair),
      .root     (root)
   );

   // the tree root holds the read pair once the counter reaches the tree depth
   assign done     = busy_ff && (cnt_ff == CW'(IW));
   assign rsp_load = done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (rsp_load) begin
         busy_in = 1'b0;
      end else if (busy_ff && !done) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   assign len_in = accept ? len_next_x[LENW-1:0] : len_ff;

   assign pend_status_in = accept ? st : pend_status_ff;
   assign pend_read_in   = accept ? rd : pend_read_ff;
   assign pend_count_in  = accept ? len_next_x[6:0] : pend_count_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.status     = pend_status_ff;
         rsp_word_in.out_first  = pend_read_ff ? root.first : NONE_VALUE;
         rsp_word_in.out_second = pend_read_ff ? root.second : NONE_VALUE;
         rsp_word_in.count      = pend_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff    <= rsp_word_in;
      pend_status_ff <= pend_status_in;
      pend_read_ff   <= pend_read_in;
      pend_count_ff  <= pend_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `PPL_ASSERT_NXT(a_len_hold, clock, reset, busy_ff && !rsp_load, len_ff == $past(len_ff), "length changed while a word is in flight")
   `PPL_ASSERT_IMP(a_len_bound, clock, reset, 1'b1, len_ff <= LENW'(DEPTH), "length above depth")
   `PPL_ASSERT_IMP(a_count_match, clock, reset, rsp_valid_ff && !busy_ff, rsp_word_ff.count == len_x[6:0], "response count differs from length")
   `PPL_ASSERT_IMP(a_cnt_bound, clock, reset, busy_ff, cnt_ff <= CW'(IW), "tree counter ran past tree depth")

endmodule

@@ hw/rtl/ppl_cell.sv @@
// one list cell: holds one pair, shifts toward or away from the head
// depends on ppl_pkg
module ppl_cell import ppl_pkg::*; #(
   parameter int IW    = 6,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [IW-1:0] at,
   input  pair_type      new_pair,
   input  pair_type      left_pair,
   input  pair_type      right_pair,
   output pair_type      pair,
   output pair_type      rd_pair
);

   localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

   pair_type pair_ff, pair_in;
   pair_type rd_ff, rd_in;
   logic     at_here;
   logic     past_at;

   assign at_here = (at == MY_INDEX);
   assign past_at = (MY_INDEX > at);

   always_comb begin
      pair_in = pair_ff;
      if (ctrl.load) begin
         unique case (ctrl.op)
            CELL_HOLD: ;
            CELL_INS: begin
               // cells behind the slot take their left neighbor
               if (past_at) pair_in = left_pair;
               else if (at_here) pair_in = new_pair;
            end
            CELL_DEL: begin
               if (past_at || at_here) pair_in = right_pair;
            end
            default: ;
         endcase
      end
   end

   // read capture uses the value before this word's shift
   assign rd_in = ctrl.load ? ((ctrl.rd && at_here) ? pair_ff : '0) : rd_ff;

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      rd_ff   <= rd_in;
   end

   assign pair    = pair_ff;
   assign rd_pair = rd_ff;

endmodule

@@ hw/rtl/ppl_chain.sv @@
// row of list cells plus a registered or-tree that gathers the read pair
// depends on ppl_pkg and ppl_cell
module ppl_chain import ppl_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int IW    = 6
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [IW-1:0] at,
   input  pair_type      new_pair,
   output pair_type      root
);

   localparam int NLEAF = 2 ** IW;

   pair_type cell_pair [DEPTH];
   pair_type leaf      [NLEAF];
   pair_type node_ff   [NLEAF-1];
   pair_type node_in   [NLEAF-1];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pair_type left_pair;
      pair_type right_pair;

      if (i == 0) begin : g_first
         assign left_pair = cell_pair[i];
      end else begin : g_left
         assign left_pair = cell_pair[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_pair = cell_pair[i];
      end else begin : g_right
         assign right_pair = cell_pair[i+1];
      end

      ppl_cell #(
         .IW    (IW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .at         (at),
         .new_pair   (new_pair),
         .left_pair  (left_pair),
         .right_pair (right_pair),
         .pair       (cell_pair[i]),
         .rd_pair    (leaf[i])
      );
   end

   // padding leaves when depth is not a power of two
   for (genvar i = DEPTH; i < NLEAF; i++) begin : g_pad
      assign leaf[i] = '0;
   end

   // heap order: node k has children 2k+1 and 2k+2, one level per cycle
   for (genvar k = 0; k < NLEAF - 1; k++) begin : g_node
      if (2 * k + 1 >= NLEAF - 1) begin : g_from_leaf
         assign node_in[k] = pair_type'(leaf[2*k+1-(NLEAF-1)] | leaf[2*k+2-(NLEAF-1)]);
      end else begin : g_from_node
         assign node_in[k] = pair_type'(node_ff[2*k+1] | node_ff[2*k+2]);
      end

      always_ff @(posedge clock) begin
         node_ff[k] <= node_in[k];
      end
   end

   assign root = node_ff[0];

endmodule
